### hdl/telemetry_frame_classifier_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the telemetry frame classifier core
// Used by the checker file; each expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_CLASSIFIER_CORE_DEFINES_SVH
`define TELEMETRY_FRAME_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TFC_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TFC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// Types and constants of the telemetry frame classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tfc_pkg;

	localparam int BUF_LEN = 64;
	localparam int IDX_W   = $clog2(BUF_LEN);
	localparam int LEN_W   = 6;
	localparam int VER_LEN = 18;

	localparam logic [7:0] LEAD_XOR   = 8'h5A;
	localparam logic [7:0] STUFF_BYTE = 8'h2B;
	localparam logic [7:0] CRC_POLY   = 8'h1D;

	typedef enum logic [1:0] {
		REQ_BYTE    = 2'd0,
		REQ_IDLE    = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_XOR   = 2'd0,
		KIND_NEW   = 2'd1,
		KIND_THIRD = 2'd2,
		KIND_CRC   = 2'd3
	} kind_t;

	// control from the sequencer to the check accumulator
	typedef struct packed {
		logic clr;
		logic en;
		logic use_xc;   // byte goes into xor and crc
		logic use_sum;  // byte goes into the sum
	} acc_ctl_t;

	typedef struct packed {
		logic [7:0] xor_v;
		logic [7:0] sum_v;
		logic [7:0] crc_v;
	} acc_t;

endpackage

`default_nettype wire

### hdl/tfc_chk_acc.sv
// ----------------------------------------------------------------------------
// tfc_chk_acc
// Check accumulator: folds one frame byte per enabled cycle into xor, sum and CRC-8.
// ----------------------------------------------------------------------------
`default_nettype none

module tfc_chk_acc import tfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  acc_ctl_t   ctl,
	input  logic [7:0] din,
	output acc_t       acc
);

	acc_t acc_q;

	// one byte of CRC-8, MSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] c;
		c = crc ^ d;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			if (ctl.use_xc) begin
				acc_q.xor_v <= acc_q.xor_v ^ din;
				acc_q.crc_v <= crc8_byte(acc_q.crc_v, din);
			end
			if (ctl.use_sum) begin
				acc_q.sum_v <= acc_q.sum_v + din;
			end
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

### hdl/telemetry_frame_classifier_core.sv
// ----------------------------------------------------------------------------
// telemetry_frame_classifier_core
// Buffers unstuffed UART bytes, checks a frame on line idle and streams it out.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                      | tuser                 | tlast
//  s_axis   | in  | [7:0] rx_byte              | [1:0] req_type        | -
//  m_axis   | out | frame_length, byte_index,  | frame_kind,           | last
//           |     | byte_value                 | version_byte          |
//
//  A received byte, a release and an idle event whose length can never pass
//  or that comes while a frame awaits release are handled in IDLE. Other idle
//  events scan the buffer one byte a cycle through the check accumulator,
//  decide, then stream n beats from the RAM's single read port. s_tready is
//  low from scan start until the frame fails or its last beat sits in the output
//  reg. Output backpressure stalls the read pointer; arst_n clears all control.
// ----------------------------------------------------------------------------
`default_nettype none

module telemetry_frame_classifier_core import tfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [5:0] frame_length, [11:6] byte_index,
	                               // [19:12] byte_value, [23:20] zero
	output logic [2:0]  m_tuser,   // [1:0] frame_kind, [2] version_byte
	output logic        m_tlast
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   cnt_q;
	logic               stuff_q;
	logic               pend_q;
	logic [IDX_W-1:0]   n_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [IDX_W-1:0]   idx_s1;
	logic               dv_s1;
	logic [7:0]         rd_data_s1;
	logic [7:0]         lead_q;
	logic [7:0]         chk_q;
	kind_t              kind_q;
	logic [LEN_W-1:0]   ver_lo_q;
	logic               has_ver_q;

	logic               m_tvalid_q;
	kind_t              o_kind_q;
	logic [LEN_W-1:0]   o_len_q;
	logic [LEN_W-1:0]   o_idx_q;
	logic [7:0]         o_val_q;
	logic               o_ver_q;
	logic               o_last_q;

	logic [7:0]         mem [BUF_LEN];

	req_t               req;
	logic [7:0]         rx;
	logic               s_acc;
	logic               drop;
	logic               wr_en;
	logic [IDX_W-1:0]   cnt_nxt;
	logic               len_ok;
	logic               advance;
	logic               issue;
	logic [IDX_W-1:0]   rd_addr;
	logic               last_in;
	acc_ctl_t           acc_ctl;
	acc_t               acc;
	logic [7:0]         neg_sum;
	logic               pass;
	kind_t              kind_d;
	logic [LEN_W-1:0]   ver_lo_d;
	logic               has_ver_d;
	logic [LEN_W:0]     ver_hi;
	logic               ver_hit;

	assign req      = req_t'(s_tuser);
	assign rx       = s_tdata;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// every second 0x2B of a frame is dropped as a stuffing byte
	assign drop    = (rx == STUFF_BYTE) && stuff_q;
	assign wr_en   = s_acc && (req == REQ_BYTE) && !drop;
	assign cnt_nxt = (cnt_q == IDX_W'(BUF_LEN - 1)) ? '0 : cnt_q + 1'b1;

	// only these lengths can ever be accepted
	assign len_ok = (cnt_q == IDX_W'(6))  || (cnt_q == IDX_W'(8))  ||
	                (cnt_q == IDX_W'(10)) || (cnt_q == IDX_W'(22)) ||
	                (cnt_q == IDX_W'(24)) || (cnt_q == IDX_W'(38));

	assign advance = !m_tvalid_q || m_tready;

	always_comb begin
		issue = 1'b0;
		if (state_q == ST_SCAN) begin
			issue = (ptr_q != n_q);
		end else if (state_q == ST_EMIT) begin
			issue = (ptr_q != n_q) && (!dv_s1 || advance);
		end
	end

	// a stalled beat keeps re-reading its own entry
	assign rd_addr = (state_q == ST_EMIT && !issue) ? idx_s1 : ptr_q;
	assign last_in = (idx_s1 == n_q - 1'b1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q] <= rx;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	assign acc_ctl.clr     = s_acc && (req == REQ_IDLE);
	assign acc_ctl.en      = (state_q == ST_SCAN) && dv_s1;
	assign acc_ctl.use_xc  = !last_in;
	assign acc_ctl.use_sum = (idx_s1 != '0) && !last_in;

	tfc_chk_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.din    (rd_data_s1),
		.acc    (acc)
	);

	assign neg_sum = 8'd0 - acc.sum_v;

	always_comb begin
		pass      = 1'b0;
		kind_d    = KIND_XOR;
		ver_lo_d  = '0;
		has_ver_d = 1'b0;
		priority if (lead_q == LEAD_XOR) begin
			if (acc.xor_v == chk_q) begin
				if (n_q == IDX_W'(24)) begin
					pass      = 1'b1;
					ver_lo_d  = LEN_W'(4);
					has_ver_d = 1'b1;
				end else if (n_q == IDX_W'(10)) begin
					pass = 1'b1;
				end
			end
		end else if (lead_q == STUFF_BYTE) begin
			priority if (n_q == IDX_W'(10) && acc.crc_v == chk_q) begin
				pass   = 1'b1;
				kind_d = KIND_CRC;
			end else if (neg_sum == chk_q) begin
				if (n_q == IDX_W'(10) || n_q == IDX_W'(6)) begin
					pass   = 1'b1;
					kind_d = KIND_NEW;
				end else if (n_q == IDX_W'(8)) begin
					pass   = 1'b1;
					kind_d = KIND_THIRD;
				end else if (n_q == IDX_W'(38)) begin
					pass      = 1'b1;
					kind_d    = KIND_NEW;
					ver_lo_d  = LEN_W'(12);
					has_ver_d = 1'b1;
				end else if (n_q == IDX_W'(22)) begin
					pass      = 1'b1;
					kind_d    = KIND_THIRD;
					ver_lo_d  = LEN_W'(3);
					has_ver_d = 1'b1;
				end
			end else begin
				pass = 1'b0;
			end
		end else begin
			if (n_q == IDX_W'(10) && acc.crc_v == chk_q) begin
				pass   = 1'b1;
				kind_d = KIND_CRC;
			end
		end
	end

	assign ver_hi  = {1'b0, ver_lo_q} + (LEN_W + 1)'(VER_LEN);
	assign ver_hit = has_ver_q && (LEN_W'(idx_s1) >= ver_lo_q) &&
	                 ({1'b0, LEN_W'(idx_s1)} < ver_hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			stuff_q    <= 1'b0;
			pend_q     <= 1'b0;
			n_q        <= '0;
			ptr_q      <= '0;
			idx_s1     <= '0;
			dv_s1      <= 1'b0;
			lead_q     <= '0;
			chk_q      <= '0;
			kind_q     <= KIND_XOR;
			ver_lo_q   <= '0;
			has_ver_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
			o_kind_q   <= KIND_XOR;
			o_len_q    <= '0;
			o_idx_q    <= '0;
			o_val_q    <= '0;
			o_ver_q    <= 1'b0;
			o_last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						unique case (req)
							REQ_BYTE: begin
								if (rx == STUFF_BYTE) begin
									stuff_q <= !stuff_q;
								end
								if (!drop) begin
									cnt_q <= cnt_nxt;
								end
							end
							REQ_IDLE: begin
								cnt_q   <= '0;
								stuff_q <= 1'b0;
								if (!pend_q && len_ok) begin
									n_q     <= cnt_q;
									ptr_q   <= '0;
									dv_s1   <= 1'b0;
									state_q <= ST_SCAN;
								end
							end
							REQ_RELEASE: begin
								pend_q <= 1'b0;
							end
							REQ_NONE: begin
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					dv_s1 <= issue;
					if (issue) begin
						idx_s1 <= ptr_q;
						ptr_q  <= ptr_q + 1'b1;
					end
					if (dv_s1) begin
						if (idx_s1 == '0) begin
							lead_q <= rd_data_s1;
						end
						if (last_in) begin
							chk_q   <= rd_data_s1;
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (pass) begin
						pend_q    <= 1'b1;
						kind_q    <= kind_d;
						ver_lo_q  <= ver_lo_d;
						has_ver_q <= has_ver_d;
						ptr_q     <= '0;
						dv_s1     <= 1'b0;
						state_q   <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (issue) begin
						dv_s1  <= 1'b1;
						idx_s1 <= ptr_q;
						ptr_q  <= ptr_q + 1'b1;
					end else if (advance) begin
						dv_s1 <= 1'b0;
					end
					if (ptr_q == n_q && !dv_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// output register: loads whenever the slot is free or being taken
			if (advance) begin
				m_tvalid_q <= (state_q == ST_EMIT) && dv_s1;
				if ((state_q == ST_EMIT) && dv_s1) begin
					o_kind_q <= kind_q;
					o_len_q  <= LEN_W'(n_q);
					o_idx_q  <= LEN_W'(idx_s1);
					o_val_q  <= rd_data_s1;
					o_ver_q  <= ver_hit;
					o_last_q <= last_in;
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, o_val_q, o_idx_q, o_len_q};
	assign m_tuser  = {o_ver_q, o_kind_q};
	assign m_tlast  = o_last_q;

endmodule

`default_nettype wire

### hdl/tfc_checker.sv
// ----------------------------------------------------------------------------
// tfc_checker
// Port-level checks on the classifier's output beats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "telemetry_frame_classifier_core_defines.svh"

module tfc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata,
	input wire [2:0]  m_tuser,
	input wire        m_tlast
);

	// stalled beat holds
	`TFC_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled beat changed")

	// no input taken while a frame is still streaming
	`TFC_ASSERT_NOW(a_busy, clk, arst_n, m_tvalid && !m_tlast, !s_tready, "input ready mid-frame")

	// beats of a frame follow without gaps and in index order
	`TFC_ASSERT_NEXT(a_seq, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[11:6] == 6'($past(m_tdata[11:6]) + 6'd1)) && (m_tdata[5:0] == $past(m_tdata[5:0])), "frame beats out of sequence")

	// last beat sits at index length-1
	`TFC_ASSERT_NOW(a_last, clk, arst_n, m_tvalid && m_tlast, 6'(m_tdata[11:6] + 6'd1) == m_tdata[5:0], "tlast at wrong index")

	// version bytes only in frames that carry a version string
	`TFC_ASSERT_NOW(a_ver, clk, arst_n, m_tvalid && m_tuser[2], (m_tdata[5:0] == 6'd24) || (m_tdata[5:0] == 6'd38) || (m_tdata[5:0] == 6'd22), "version flag in short frame")

endmodule

bind telemetry_frame_classifier_core tfc_checker u_tfc_checker (.*);

`default_nettype wire
